// ===== rtl/core/iws_pkg.sv =====
`default_nettype none

package iws_pkg;

  // image geometry and storage
  localparam int unsigned PLANES           = 3;
  localparam int unsigned MAX_PLANE_PIXELS = 65536;
  localparam int unsigned PIXEL_BITS       = 16;

  // field widths
  localparam int unsigned PLANE_W  = 2;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned DIM_W    = 9;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;
  localparam int unsigned RESET_DIM  = 256;

  // derived widths
  localparam int unsigned PLANE_IDX_W = $clog2(MAX_PLANE_PIXELS);
  localparam int unsigned SIZE_W      = $clog2(MAX_PLANE_PIXELS + 1);
  localparam int unsigned AREA_W      = 2 * DIM_W;
  localparam int unsigned NBR_W       = IDX_W + 1;
  localparam int unsigned CMP_W       = (NBR_W > SIZE_W) ? NBR_W : SIZE_W;
  localparam int unsigned STORE_DEPTH = PLANES * MAX_PLANE_PIXELS;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  // blend arithmetic
  localparam int unsigned INV_W  = WEIGHT_W + 1;
  localparam int unsigned BW     = 2 * WEIGHT_W + 1;
  localparam int unsigned PW     = PIXEL_BITS + BW;
  localparam int unsigned ACC_W  = PW + 2;
  localparam int unsigned FRAC_W = 2 * WEIGHT_W;
  localparam int unsigned RES_W  = ACC_W - FRAC_W;

  // neighbor lanes
  localparam int unsigned NBRS   = 4;
  localparam int unsigned NB_00  = 0;
  localparam int unsigned NB_10  = 1;
  localparam int unsigned NB_01  = 2;
  localparam int unsigned NB_11  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP_MODE = 2'd0,
    CFG_IMAGE_ROWS  = 2'd1,
    CFG_IMAGE_COLS  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    MODE_BILINEAR = 1'b0,
    MODE_NEAREST  = 1'b1
  } interp_mode_e;

  // memory access for one item
  typedef struct packed {
    logic                             wr_en;
    logic [STORE_AW-1:0]              wr_addr;
    logic [PIXEL_BITS-1:0]            wr_data;
    logic [NBRS-1:0][STORE_AW-1:0]    rd_addr;
  } store_req_t;

  // sample control that travels beside the memory read
  typedef struct packed {
    logic                 valid;
    logic                 oor;
    logic [NBRS-1:0]      use_nbr;
    logic [WEIGHT_W-1:0]  wr;
    logic [WEIGHT_W-1:0]  wc;
  } blend_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/iws_addr.sv =====
`default_nettype none

module iws_addr (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            operation_i,
  input  logic [iws_pkg::PLANE_W-1:0]     plane_i,
  input  logic [iws_pkg::IDX_W-1:0]       pixel_index_i,
  input  logic [iws_pkg::VALUE_W-1:0]     pixel_value_i,
  input  logic [iws_pkg::WEIGHT_W-1:0]    weight_row_i,
  input  logic [iws_pkg::WEIGHT_W-1:0]    weight_col_i,
  input  logic                            interp_mode_i,
  input  logic [iws_pkg::DIM_W-1:0]       image_rows_i,
  input  logic [iws_pkg::DIM_W-1:0]       image_cols_i,
  output iws_pkg::store_req_t             req_o,
  output iws_pkg::blend_ctl_t             ctl_o
);
  import iws_pkg::*;

  logic                           plane_ok;
  logic [PLANE_W-1:0]             plane_sel;
  logic [AREA_W-1:0]              area;
  logic [SIZE_W-1:0]              size;
  logic [NBRS-1:0][NBR_W-1:0]     nbr;
  logic [NBRS-1:0]                in_rng;
  logic [NBRS-1:0]                needed;
  logic [NBRS-1:0][STORE_AW-1:0]  addr;
  logic                           nearest;
  logic [WEIGHT_W-1:0]            wr_eff;
  logic [WEIGHT_W-1:0]            wc_eff;
  logic                           wr_nz;
  logic                           wc_nz;

  logic                           wr_en_q;
  logic                           smp_q;
  logic [STORE_AW-1:0]            wr_addr_q;
  logic [PIXEL_BITS-1:0]          wr_data_q;
  logic [NBRS-1:0][STORE_AW-1:0]  rd_addr_q;
  logic                           oor_q;
  logic [NBRS-1:0]                use_q;
  logic [WEIGHT_W-1:0]            wr_q;
  logic [WEIGHT_W-1:0]            wc_q;

  always_comb begin
    plane_ok  = ({1'b0, plane_i} < (PLANE_W + 1)'(PLANES));
    plane_sel = plane_ok ? plane_i : '0;
    area      = AREA_W'(image_rows_i) * AREA_W'(image_cols_i);
    size      = (area > AREA_W'(MAX_PLANE_PIXELS)) ? SIZE_W'(MAX_PLANE_PIXELS)
                                                    : SIZE_W'(area);

    // nearest mode behaves as a blend with both fractions at zero
    nearest = (interp_mode_i == MODE_NEAREST);
    wr_eff  = nearest ? '0 : weight_row_i;
    wc_eff  = nearest ? '0 : weight_col_i;
    wr_nz   = |wr_eff;
    wc_nz   = |wc_eff;

    nbr[NB_00] = NBR_W'(pixel_index_i);
    nbr[NB_10] = nbr[NB_00] + NBR_W'(1);
    nbr[NB_01] = nbr[NB_00] + NBR_W'(image_rows_i);
    nbr[NB_11] = nbr[NB_01] + NBR_W'(1);

    needed[NB_00] = 1'b1;
    needed[NB_10] = wr_nz;
    needed[NB_01] = wc_nz;
    needed[NB_11] = wr_nz & wc_nz;

    for (int k = 0; k < NBRS; k++) begin
      in_rng[k] = plane_ok && (CMP_W'(nbr[k]) < CMP_W'(size));
      addr[k]   = STORE_AW'(plane_sel) * STORE_AW'(MAX_PLANE_PIXELS)
                + STORE_AW'(nbr[k][PLANE_IDX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
      smp_q   <= 1'b0;
    end else begin
      wr_en_q <= accept_i && (operation_i == OP_LOAD) && in_rng[NB_00];
      smp_q   <= accept_i && (operation_i == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= addr[NB_00];
    wr_data_q <= PIXEL_BITS'(pixel_value_i);
    rd_addr_q <= addr;
    oor_q     <= |(needed & ~in_rng);
    use_q     <= needed & in_rng;
    wr_q      <= wr_eff;
    wc_q      <= wc_eff;
  end

  assign req_o.wr_en   = wr_en_q;
  assign req_o.wr_addr = wr_addr_q;
  assign req_o.wr_data = wr_data_q;
  assign req_o.rd_addr = rd_addr_q;

  assign ctl_o.valid   = smp_q;
  assign ctl_o.oor     = oor_q;
  assign ctl_o.use_nbr = use_q;
  assign ctl_o.wr      = wr_q;
  assign ctl_o.wc      = wc_q;

endmodule

`default_nettype wire

// ===== rtl/core/iws_store.sv =====
`default_nettype none

module iws_store (
  input  logic                                              clk_i,
  input  iws_pkg::store_req_t                               req_i,
  output logic [iws_pkg::NBRS-1:0][iws_pkg::PIXEL_BITS-1:0] rdata_o
);
  import iws_pkg::*;

  // two identical copies, each with two read ports
  logic [PIXEL_BITS-1:0]            mem_a_q [STORE_DEPTH];
  logic [PIXEL_BITS-1:0]            mem_b_q [STORE_DEPTH];
  logic [NBRS-1:0][PIXEL_BITS-1:0]  rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_a_q[req_i.wr_addr] <= req_i.wr_data;
      mem_b_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q[NB_00] <= mem_a_q[req_i.rd_addr[NB_00]];
    rdata_q[NB_10] <= mem_a_q[req_i.rd_addr[NB_10]];
    rdata_q[NB_01] <= mem_b_q[req_i.rd_addr[NB_01]];
    rdata_q[NB_11] <= mem_b_q[req_i.rd_addr[NB_11]];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/iws_blend.sv =====
`default_nettype none

module iws_blend (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  iws_pkg::blend_ctl_t                               ctl_i,
  input  logic [iws_pkg::NBRS-1:0][iws_pkg::PIXEL_BITS-1:0] rdata_i,
  output logic                                              strobe_o,
  output logic [iws_pkg::OUT_W-1:0]                         value_o,
  output logic                                              oor_o
);
  import iws_pkg::*;

  localparam logic [INV_W-1:0]  WEIGHT_ONE = {1'b1, {WEIGHT_W{1'b0}}};
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic [RES_W-1:0]  OUT_MAX    = RES_W'({OUT_W{1'b1}});

  logic [INV_W-1:0]             inv_r;
  logic [INV_W-1:0]             inv_c;
  logic [2*INV_W-1:0]           w00_full;
  logic [2*INV_W-1:0]           w10_full;
  logic [2*INV_W-1:0]           w01_full;
  logic [2*INV_W-1:0]           w11_full;
  logic [NBRS-1:0][BW-1:0]      w_d;

  logic                         vld_a_q;
  logic                         oor_a_q;
  logic [NBRS-1:0]              use_a_q;
  logic [NBRS-1:0][BW-1:0]      w_a_q;

  logic [NBRS-1:0][PW-1:0]      prod_d;
  logic                         vld_b_q;
  logic                         oor_b_q;
  logic [NBRS-1:0][PW-1:0]      prod_b_q;

  logic [ACC_W-1:0]             acc;
  logic [RES_W-1:0]             res;
  logic                         vld_q;
  logic                         oor_q;
  logic [OUT_W-1:0]             value_q;

  // stage a: corner weights in Q1.32, in parallel with the memory read
  always_comb begin
    inv_r    = WEIGHT_ONE - INV_W'(ctl_i.wr);
    inv_c    = WEIGHT_ONE - INV_W'(ctl_i.wc);
    w00_full = inv_r * inv_c;
    w10_full = INV_W'(ctl_i.wr) * inv_c;
    w01_full = inv_r * INV_W'(ctl_i.wc);
    w11_full = INV_W'(ctl_i.wr) * INV_W'(ctl_i.wc);
    w_d[NB_00] = w00_full[BW-1:0];
    w_d[NB_10] = w10_full[BW-1:0];
    w_d[NB_01] = w01_full[BW-1:0];
    w_d[NB_11] = w11_full[BW-1:0];
  end

  // stage b: pixel times weight, neighbors not used read as zero
  always_comb begin
    for (int k = 0; k < NBRS; k++) begin
      prod_d[k] = use_a_q[k] ? PW'(rdata_i[k]) * PW'(w_a_q[k]) : '0;
    end
  end

  // stage c: sum, round half up, saturate
  always_comb begin
    acc = ACC_W'(prod_b_q[NB_00]) + ACC_W'(prod_b_q[NB_10])
        + ACC_W'(prod_b_q[NB_01]) + ACC_W'(prod_b_q[NB_11]) + ROUND_HALF;
    res = acc[ACC_W-1:FRAC_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      vld_a_q <= ctl_i.valid;
      vld_b_q <= vld_a_q;
      vld_q   <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oor_a_q  <= ctl_i.oor;
    use_a_q  <= ctl_i.use_nbr;
    w_a_q    <= w_d;
    oor_b_q  <= oor_a_q;
    prod_b_q <= prod_d;
    oor_q    <= oor_b_q;
    value_q  <= (res > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : res[OUT_W-1:0];
  end

  assign strobe_o = vld_q;
  assign value_o  = value_q;
  assign oor_o    = oor_q;

endmodule

`default_nettype wire

// ===== rtl/core/image_warp_sampler_top.sv =====
`default_nettype none

// image warp sampler: bilinear or nearest sampling of a three-plane image
//
// input channel: a transaction is taken at a rising edge with start high and
// busy low; busy is never raised, so one transaction can enter every clock.
// operation 0 loads pixel_value into the plane at pixel_index (dropped when
// outside the plane); operation 1 samples the plane at pixel_index.
// output channel: each sample gives one result, shown for one clock with
// sample_strobe_o high; loads give none. the result is registered after the
// address, read, product and sum stages; results leave in order, and the
// receiver cannot stall.
// throughput: one transaction per clock, set by the four neighbor reads,
// served by two copies of the pixel store with two read ports each.
// pipeline: address/range check, store read with weight products, pixel by
// weight products, sum with rounding and saturation.
// configuration: plain write port, index 0 interp_mode, 1 image_rows,
// 2 image_cols; write only while no transaction is in flight.
// reset: bilinear mode, 256 by 256 plane, pipeline emptied; the store is not
// cleared and a pixel must be loaded before it is sampled.

module image_warp_sampler_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [iws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [iws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input transactions
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [iws_pkg::PLANE_W-1:0]        plane_i,
  input  logic [iws_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic [iws_pkg::VALUE_W-1:0]        pixel_value_i,
  input  logic [iws_pkg::WEIGHT_W-1:0]       weight_row_i,
  input  logic [iws_pkg::WEIGHT_W-1:0]       weight_col_i,
  // results
  output logic                               sample_strobe_o,
  output logic [iws_pkg::OUT_W-1:0]          sample_value_o,
  output logic                               out_of_range_o
);
  import iws_pkg::*;

  logic                 interp_mode_q;
  logic [DIM_W-1:0]     image_rows_q;
  logic [DIM_W-1:0]     image_cols_q;
  logic                 accept;
  store_req_t           req;
  blend_ctl_t           ctl;
  logic [NBRS-1:0][PIXEL_BITS-1:0] rdata;

  // the pipeline never holds off an input transaction
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_mode_q <= MODE_BILINEAR;
      image_rows_q  <= DIM_W'(RESET_DIM);
      image_cols_q  <= DIM_W'(RESET_DIM);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INTERP_MODE: interp_mode_q <= cfg_wdata_i[0];
        CFG_IMAGE_ROWS:  image_rows_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_COLS:  image_cols_q  <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: plane size, neighbor addresses, range flags, load write
  iws_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .plane_i       (plane_i),
    .pixel_index_i (pixel_index_i),
    .pixel_value_i (pixel_value_i),
    .weight_row_i  (weight_row_i),
    .weight_col_i  (weight_col_i),
    .interp_mode_i (interp_mode_q),
    .image_rows_i  (image_rows_q),
    .image_cols_i  (image_cols_q),
    .req_o         (req),
    .ctl_o         (ctl)
  );

  // stage 2: load write and four neighbor reads in the same stage, so a
  // sample right behind a load sees the new pixel
  iws_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // stages 2 to 4: weights, products, rounded sum
  iws_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rdata_i  (rdata),
    .strobe_o (sample_strobe_o),
    .value_o  (sample_value_o),
    .oor_o    (out_of_range_o)
  );

`ifndef SYNTHESIS
  // every result comes from a sample transaction taken at an earlier accepting edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_strobe_o |-> $past(start && !busy && operation_i == OP_SAMPLE, 4))
    else $error("result strobe without a matching sample transaction");

  // a sample of a missing plane gives zero with the range flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_SAMPLE
     && ({1'b0, plane_i} >= (PLANE_W + 1)'(PLANES)))
    |-> ##4 (sample_strobe_o && out_of_range_o && sample_value_o == '0))
    else $error("missing plane sample did not read zero with flag");
`endif

endmodule

`default_nettype wire

// ===== test/image_warp_sampler_top_test.sv =====
`default_nettype none

module image_warp_sampler_top_test;

  import iws_pkg::*;

  // nothing accepted on either side for this many cycles means a hang
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // strobe comes through the pipeline stages after the accepting edge, loads retire late too
  localparam int unsigned SETTLE_CYCLES  = 8;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PER_PHASE = 75;

  typedef struct {
    op_e                  op;
    logic [PLANE_W-1:0]   plane;
    logic [IDX_W-1:0]     idx;
    logic [VALUE_W-1:0]   value;
    logic [WEIGHT_W-1:0]  wr;
    logic [WEIGHT_W-1:0]  wc;
  } warp_txn_t;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic             oor;
  } sample_t;

  // clock, reset and block inputs, all known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  start         = 1'b0;
  logic                  operation_i   = 1'b0;
  logic [PLANE_W-1:0]    plane_i       = '0;
  logic [IDX_W-1:0]      pixel_index_i = '0;
  logic [VALUE_W-1:0]    pixel_value_i = '0;
  logic [WEIGHT_W-1:0]   weight_row_i  = '0;
  logic [WEIGHT_W-1:0]   weight_col_i  = '0;

  wire                   busy;
  wire                   sample_strobe_o;
  wire [OUT_W-1:0]       sample_value_o;
  wire                   out_of_range_o;

  // transactions waiting for the driver, samples waiting for their result
  warp_txn_t txn_q[$];
  sample_t   sample_exp_q[$];
  warp_txn_t drv_txn;

  // predictor copy of the image and of the registers
  logic [PIXEL_BITS-1:0] pix_store [PLANES][MAX_PLANE_PIXELS];
  interp_mode_e          mode_cfg = MODE_BILINEAR;
  int unsigned           rows_cfg = RESET_DIM;
  int unsigned           cols_cfg = RESET_DIM;

  // stimulus side view of which pixels hold a loaded value
  bit loaded_gen [PLANES][MAX_PLANE_PIXELS];

  int unsigned send_idle_pct = 14;
  int unsigned n_counted     = 0;
  int unsigned n_loads       = 0;
  int unsigned n_samples     = 0;
  int unsigned n_results     = 0;
  int unsigned n_cfg_writes  = 0;
  int unsigned n_phases      = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned stall_cycles  = 0;

  image_warp_sampler_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .plane_i         (plane_i),
    .pixel_index_i   (pixel_index_i),
    .pixel_value_i   (pixel_value_i),
    .weight_row_i    (weight_row_i),
    .weight_col_i    (weight_col_i),
    .sample_strobe_o (sample_strobe_o),
    .sample_value_o  (sample_value_o),
    .out_of_range_o  (out_of_range_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // plane size from rows and cols, capped at the store size per plane
  function automatic int unsigned plane_pixels();
    int unsigned n;
    n = rows_cfg * cols_cfg;
    return (n > MAX_PLANE_PIXELS) ? MAX_PLANE_PIXELS : n;
  endfunction

  // one neighbor; outside the plane it reads zero and flags if its weight counts
  function automatic longint unsigned read_pixel(input logic [PLANE_W-1:0] plane,
                                                 input int unsigned n, input bit needed,
                                                 input int unsigned size, inout bit oor);
    if (plane >= PLANES || n >= size) begin
      if (needed) oor = 1'b1;
      return 0;
    end
    return pix_store[plane][n];
  endfunction

  // nearest copy or exact Q1.32 four-neighbor blend, rounded half up
  function automatic sample_t blend_sample(input warp_txn_t t);
    sample_t           s;
    int unsigned       size;
    int unsigned       base;
    bit                oor;
    longint unsigned   one, wr, wc, p00, p10, p01, p11, acc, res;
    size = plane_pixels();
    base = t.idx;
    oor  = 1'b0;
    one  = 65536;
    wr   = t.wr;
    wc   = t.wc;
    if (mode_cfg == MODE_NEAREST) begin
      res = read_pixel(t.plane, base, 1'b1, size, oor);
    end else begin
      p00 = read_pixel(t.plane, base, 1'b1, size, oor);
      p10 = read_pixel(t.plane, base + 1, wr != 0, size, oor);
      p01 = read_pixel(t.plane, base + rows_cfg, wc != 0, size, oor);
      p11 = read_pixel(t.plane, base + rows_cfg + 1, wr != 0 && wc != 0, size, oor);
      acc = p00 * (one - wr) * (one - wc) + p10 * wr * (one - wc)
          + p01 * (one - wr) * wc + p11 * wr * wc;
      res = (acc + 64'h8000_0000) >> 32;
    end
    if (res > 65535) res = 65535;
    s.value = res[OUT_W-1:0];
    s.oor   = oor;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued transactions, predicts each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      // transaction taken at this edge: update the image copy or predict a result
      if (start && !busy) begin
        if (drv_txn.op == OP_LOAD) begin
          n_loads++;
          if (drv_txn.plane < PLANES && drv_txn.idx < plane_pixels())
            pix_store[drv_txn.plane][drv_txn.idx] = drv_txn.value;
        end else begin
          n_samples++;
          sample_exp_q.push_back(blend_sample(drv_txn));
        end
      end
      // slot is free: present the next transaction or leave a gap
      if (!start || !busy) begin
        if (txn_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_txn = txn_q.pop_front();
          start         <= 1'b1;
          operation_i   <= drv_txn.op;
          plane_i       <= drv_txn.plane;
          pixel_index_i <= drv_txn.idx;
          pixel_value_i <= drv_txn.value;
          weight_row_i  <= drv_txn.wr;
          weight_col_i  <= drv_txn.wc;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe is checked against the oldest predicted sample
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk_i) begin
    sample_t exp_s;
    if (rst_ni && sample_strobe_o) begin
      n_results++;
      if (sample_exp_q.size() == 0) begin
        report_mismatch("result with no sample pending, sample_value", 0, sample_value_o);
      end else begin
        exp_s = sample_exp_q.pop_front();
        if (sample_value_o !== exp_s.value)
          report_mismatch("sample_value", exp_s.value, sample_value_o);
        if (out_of_range_o !== exp_s.oor)
          report_mismatch("out_of_range", exp_s.oor, out_of_range_o);
      end
    end
  end

  // watchdog: restarts whenever either side moves a transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || sample_strobe_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, stall_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write while idle; the predictor copy follows after the write edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_cfg_writes++;
    case (index)
      CFG_INTERP_MODE: mode_cfg = interp_mode_e'(data[0]);
      CFG_IMAGE_ROWS:  rows_cfg = data[CFG_DATA_W-1:0];
      CFG_IMAGE_COLS:  cols_cfg = data[CFG_DATA_W-1:0];
      default: ;
    endcase
  endtask

  // sender holds off until every predicted sample has come back, then settles
  task automatic wait_drained();
    @(negedge clk_i);
    while (txn_q.size() != 0 || start || sample_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_load(input logic [PLANE_W-1:0] plane, input int unsigned idx,
                           input logic [VALUE_W-1:0] value);
    warp_txn_t t;
    t.op    = OP_LOAD;
    t.plane = plane;
    t.idx   = idx[IDX_W-1:0];
    t.value = value;
    t.wr    = $urandom;
    t.wc    = $urandom;
    txn_q.push_back(t);
    // loads outside the plane are dropped and do not count toward the run
    if (plane < PLANES && idx < plane_pixels()) begin
      loaded_gen[plane][idx] = 1'b1;
      n_counted++;
    end
  endtask

  task automatic push_sample(input logic [PLANE_W-1:0] plane, input int unsigned idx,
                             input logic [WEIGHT_W-1:0] wr, input logic [WEIGHT_W-1:0] wc);
    warp_txn_t t;
    t.op    = OP_SAMPLE;
    t.plane = plane;
    t.idx   = idx[IDX_W-1:0];
    t.value = $urandom;
    t.wr    = wr;
    t.wc    = wc;
    txn_q.push_back(t);
    n_counted++;
  endtask

  // every in-plane pixel the block may read must already hold a loaded value
  function automatic bit sample_legal(input logic [PLANE_W-1:0] plane,
                                      input int unsigned idx);
    int unsigned size;
    int unsigned n;
    size = plane_pixels();
    if (plane >= PLANES) return 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (mode_cfg == MODE_NEAREST && k > 0) break;
      n = idx + (k[0] ? 1 : 0) + (k[1] ? rows_cfg : 0);
      if (n < size && !loaded_gen[plane][n]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // weights lean on the corners: zero, full scale, one half and one lsb
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return 16'h0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic try_sample(input logic [PLANE_W-1:0] plane, input int unsigned idx);
    if (sample_legal(plane, idx)) push_sample(plane, idx, rand_weight(), rand_weight());
  endtask

  // patch corner: mostly inside the plane, sometimes at its last row or column
  function automatic int unsigned pick_base(input int unsigned size);
    int unsigned r;
    r = $urandom_range(9);
    if (size == 0 || r == 0) return $urandom_range(16'hFFFF);
    if (r == 1) return size - 1;
    if (r == 2 && size > rows_cfg) return size - rows_cfg - 1;
    return $urandom_range(size - 1);
  endfunction

  function automatic int unsigned rand_index(input int unsigned size);
    if (size == 0 || $urandom_range(3) == 0) return $urandom_range(16'hFFFF);
    return $urandom_range(size - 1);
  endfunction

  // one geometry: mostly 2x2 patch loads followed by samples on them, plus noise
  task automatic random_phase(input interp_mode_e mode, input int unsigned rows,
                              input int unsigned cols);
    int unsigned       size;
    int unsigned       base;
    int unsigned       n;
    int unsigned       r;
    int unsigned       first_cnt;
    int unsigned       pick;
    bit                paused;
    logic [PLANE_W-1:0] p;
    int unsigned       bases[$];
    write_reg(CFG_INTERP_MODE, mode);
    write_reg(CFG_IMAGE_ROWS, rows);
    write_reg(CFG_IMAGE_COLS, cols);
    n_phases++;
    size      = plane_pixels();
    first_cnt = n_counted;
    paused    = 1'b0;
    while (n_counted - first_cnt < RANDOM_PER_PHASE) begin
      // halfway through, the sender waits for every result
      if (!paused && n_counted - first_cnt >= RANDOM_PER_PHASE / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 55) begin
        p    = $urandom_range(PLANES - 1);
        base = pick_base(size);
        for (int k = 0; k < 4; k++) begin
          n = base + (k[0] ? 1 : 0) + (k[1] ? rows_cfg : 0);
          if (n <= 16'hFFFF) push_load(p, n, $urandom);
        end
        bases.push_back(p * MAX_PLANE_PIXELS + base);
        repeat ($urandom_range(1, 3)) try_sample(p, base);
      end else if (r < 75 && bases.size() > 0) begin
        pick = bases[$urandom_range(bases.size() - 1)];
        try_sample(pick / MAX_PLANE_PIXELS, pick % MAX_PLANE_PIXELS);
      end else if (r < 85) begin
        push_load($urandom_range(3), rand_index(size), $urandom);
      end else begin
        try_sample($urandom_range(3), rand_index(size));
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 4 rows by 3 cols, bilinear
    write_reg(CFG_INTERP_MODE, MODE_BILINEAR);
    write_reg(CFG_IMAGE_ROWS, 4);
    write_reg(CFG_IMAGE_COLS, 3);
    push_load(0, 0, 16'hFFFF);
    push_load(0, 1, 16'h0000);
    push_load(0, 4, 16'h1234);
    push_load(0, 5, 16'hFFFF);
    push_sample(0, 0, 16'h0000, 16'h0000);
    push_sample(0, 0, 16'hFFFF, 16'hFFFF);
    push_sample(0, 0, 16'h8000, 16'h8000);
    // last pixel of the plane: right and lower neighbors fall outside
    push_load(2, 11, 16'hABCD);
    push_sample(2, 11, 16'h0001, 16'h0000);
    push_sample(2, 11, 16'hFFFF, 16'hFFFF);
    // last row: the next-row neighbor is the top of the next column
    push_load(1, 3, 16'h7777);
    push_load(1, 4, 16'h0101);
    push_load(1, 7, 16'hC3C3);
    push_load(1, 8, 16'h0F0F);
    push_sample(1, 3, 16'd40000, 16'd20000);
    // missing plane and loads that land outside the plane
    push_load(3, 0, 16'h5A5A);
    push_sample(3, 0, 16'h1111, 16'h2222);
    push_load(0, 12, 16'hDEAD);
    push_load(0, 16'hFFFF, 16'hBEEF);
    push_sample(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // write to the unused index must not disturb anything, then nearest copy
    write_reg(CFG_UNUSED, 9'h1FF);
    write_reg(CFG_INTERP_MODE, MODE_NEAREST);
    push_sample(0, 0, $urandom, $urandom);
    push_sample(0, 12, $urandom, $urandom);
    wait_drained();

    // zero rows: plane is empty, loads drop and every sample flags
    write_reg(CFG_IMAGE_ROWS, 0);
    push_load(0, 0, 16'h4321);
    push_sample(0, 0, $urandom, $urandom);
    wait_drained();

    // random: sender gaps 14 percent
    send_idle_pct = 14;
    random_phase(MODE_BILINEAR, 4, 4);
    random_phase(MODE_NEAREST, 5, 3);

    // sender gaps 76 percent, full size plane and a single row
    send_idle_pct = 76;
    random_phase(MODE_BILINEAR, 256, 256);
    random_phase(MODE_BILINEAR, 1, 256);

    // back to back, no gaps
    send_idle_pct = 0;
    random_phase(MODE_BILINEAR, 256, 1);
    random_phase(MODE_NEAREST, 256, 256);
    random_phase(MODE_BILINEAR, $urandom_range(2, 9), $urandom_range(2, 9));
    random_phase(MODE_BILINEAR, 1, 1);

    wait_drained();
    $display("covered %0d loads and %0d samples in, %0d results checked",
             n_loads, n_samples, n_results);
    $display("over %0d register writes, %0d random geometries, both modes, rows 0 to 256",
             n_cfg_writes, n_phases);
    if (mismatch_cnt == 0 && sample_exp_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/iws_pkg.sv
rtl/core/iws_addr.sv
rtl/core/iws_store.sv
rtl/core/iws_blend.sv
rtl/core/image_warp_sampler_top.sv
test/image_warp_sampler_top_test.sv
